@@ rtl/imubac_pkg.sv @@
// Package for the IMU bias auto-calibrator: shared types, register indexes,
// reset values and the saturating bias adder. No dependencies.
`timescale 1ns / 1ps

package imubac_pkg;

  localparam int unsigned BiasW  = 16;
  localparam int unsigned StepW  = 7;
  localparam int unsigned CountW = 8;
  localparam int unsigned GravW  = 15;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [StepW-1:0]  CoarseStepRst   = 7'd10;
  localparam logic [StepW-1:0]  FineStepRst     = 7'd2;
  localparam logic [CountW-1:0] SwitchCountRst  = 8'd40;
  localparam logic [CountW-1:0] TotalSamplesRst = 8'd100;
  localparam logic [GravW-1:0]  GravityRst      = 15'h4000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgInitBiasX   = 3'd0,
    CfgInitBiasY   = 3'd1,
    CfgInitBiasZ   = 3'd2,
    CfgCoarseStep  = 3'd3,
    CfgFineStep    = 3'd4,
    CfgSwitchCount = 3'd5,
    CfgTotalSmp    = 3'd6,
    CfgGravity     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [BiasW-1:0] init_x;
    logic signed [BiasW-1:0] init_y;
    logic signed [BiasW-1:0] init_z;
    logic [StepW-1:0]        coarse_step;
    logic [StepW-1:0]        fine_step;
    logic [CountW-1:0]       switch_count;
    logic [CountW-1:0]       total_samples;
    logic [GravW-1:0]        gravity_target;
  } cfg_t;

  typedef struct packed {
    logic signed [BiasW-1:0] accel_x;
    logic signed [BiasW-1:0] accel_y;
    logic signed [BiasW-1:0] accel_z;
    logic signed [BiasW-1:0] gyro_x;
    logic signed [BiasW-1:0] gyro_y;
    logic signed [BiasW-1:0] gyro_z;
  } sample_t;

  typedef struct packed {
    logic signed [BiasW-1:0] acc_x;
    logic signed [BiasW-1:0] acc_y;
    logic signed [BiasW-1:0] acc_z;
    logic signed [BiasW-1:0] gyr_x;
    logic signed [BiasW-1:0] gyr_y;
    logic signed [BiasW-1:0] gyr_z;
    logic [CountW-1:0]       seen;
  } state_t;

  // Add a signed delta (at most a step's magnitude) and clamp to 16 bits.
  function automatic logic signed [BiasW-1:0] sat_add(
    input logic signed [BiasW-1:0] b,
    input logic signed [StepW+1:0] d
  );
    logic signed [BiasW:0] sum;
    sum = {b[BiasW-1], b} + {{(BiasW-StepW-1){d[StepW+1]}}, d};
    if (sum[BiasW] != sum[BiasW-1]) begin
      sat_add = sum[BiasW] ? {1'b1, {(BiasW-1){1'b0}}} : {1'b0, {(BiasW-1){1'b1}}};
    end else begin
      sat_add = sum[BiasW-1:0];
    end
  endfunction

endpackage

@@ rtl/imubac_if.sv @@
// Handshake channels of the IMU bias auto-calibrator: sample and result words.
// Depends on imubac_pkg for field widths.
`timescale 1ns / 1ps

interface imubac_sample_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [imubac_pkg::BiasW-1:0]    accel_x;
  logic signed [imubac_pkg::BiasW-1:0]    accel_y;
  logic signed [imubac_pkg::BiasW-1:0]    accel_z;
  logic signed [imubac_pkg::BiasW-1:0]    gyro_x;
  logic signed [imubac_pkg::BiasW-1:0]    gyro_y;
  logic signed [imubac_pkg::BiasW-1:0]    gyro_z;

  modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  output ready);
endinterface

interface imubac_result_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [imubac_pkg::BiasW-1:0]    accel_bias_x_out;
  logic signed [imubac_pkg::BiasW-1:0]    accel_bias_y_out;
  logic signed [imubac_pkg::BiasW-1:0]    accel_bias_z_out;
  logic signed [imubac_pkg::BiasW-1:0]    gyro_bias_x_out;
  logic signed [imubac_pkg::BiasW-1:0]    gyro_bias_y_out;
  logic signed [imubac_pkg::BiasW-1:0]    gyro_bias_z_out;
  logic                                   done_res;

  modport source (output valid, accel_bias_x_out, accel_bias_y_out, accel_bias_z_out,
                  gyro_bias_x_out, gyro_bias_y_out, gyro_bias_z_out, done_res,
                  input ready);
  modport sink   (input valid, accel_bias_x_out, accel_bias_y_out, accel_bias_z_out,
                  gyro_bias_x_out, gyro_bias_y_out, gyro_bias_z_out, done_res,
                  output ready);
endinterface

@@ rtl/imu_bias_auto_calibrator_unit.sv @@
// Top level of the IMU bias auto-calibrator: config registers, sample and
// result registers, bias state. Depends on imubac_pkg, imubac_if, imubac_update.
`timescale 1ns / 1ps

// Usage
//   sample_i carries one inertial word (three accel and three gyro axes);
//   result_o returns one word per sample: the six biases after that sample
//   and done_res, set once the run has taken total_samples samples. Later
//   samples leave the biases alone and still get a result with done_res set.
//   The configuration port writes one register per cycle while cfg_we_i is
//   high; write it only while no sample is in flight.
// Pipeline
//   The accepting edge loads the sample register; the update then moves
//   into the result register once that one is free or being drained.
//   One word per cycle sustained while result_o.ready stays high; the bias
//   state feeds back through combinational update logic.
// Reset
//   Registers return to their reset values, biases and sample count clear,
//   both pipeline registers empty.
// Stall
//   When result_o.ready is low with a word held, the word in the sample
//   register waits, and sample_i.ready drops once that register is full too.
module imu_bias_auto_calibrator_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [imubac_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [imubac_pkg::CfgDataW-1:0]  cfg_wdata_i,
  imubac_sample_if.sink                    sample_i,
  imubac_result_if.source                  result_o
);
  import imubac_pkg::*;

  cfg_t    cfg_q;
  state_t  st_q;
  state_t  st_d;
  sample_t smp_q;
  logic    smp_vld_q;
  logic    res_vld_q;
  logic    res_done_q;
  logic    done_d;
  logic    adv;
  state_t  res_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.init_x         <= '0;
      cfg_q.init_y         <= '0;
      cfg_q.init_z         <= '0;
      cfg_q.coarse_step    <= CoarseStepRst;
      cfg_q.fine_step      <= FineStepRst;
      cfg_q.switch_count   <= SwitchCountRst;
      cfg_q.total_samples  <= TotalSamplesRst;
      cfg_q.gravity_target <= GravityRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgInitBiasX:   cfg_q.init_x         <= cfg_wdata_i;
        CfgInitBiasY:   cfg_q.init_y         <= cfg_wdata_i;
        CfgInitBiasZ:   cfg_q.init_z         <= cfg_wdata_i;
        CfgCoarseStep:  cfg_q.coarse_step    <= cfg_wdata_i[StepW-1:0];
        CfgFineStep:    cfg_q.fine_step      <= cfg_wdata_i[StepW-1:0];
        CfgSwitchCount: cfg_q.switch_count   <= cfg_wdata_i[CountW-1:0];
        CfgTotalSmp:    cfg_q.total_samples  <= cfg_wdata_i[CountW-1:0];
        CfgGravity:     cfg_q.gravity_target <= cfg_wdata_i[GravW-1:0];
        default: ;
      endcase
    end
  end

  // Advance the sample register into the result register when that one is
  // free or being drained this cycle.
  assign adv            = smp_vld_q && (!res_vld_q || result_o.ready);
  assign sample_i.ready = !smp_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_vld_q <= 1'b0;
    end else if (sample_i.ready) begin
      smp_vld_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.valid && sample_i.ready) begin
      smp_q.accel_x <= sample_i.accel_x;
      smp_q.accel_y <= sample_i.accel_y;
      smp_q.accel_z <= sample_i.accel_z;
      smp_q.gyro_x  <= sample_i.gyro_x;
      smp_q.gyro_y  <= sample_i.gyro_y;
      smp_q.gyro_z  <= sample_i.gyro_z;
    end
  end

  imubac_update u_update (
    .cfg_i  (cfg_q),
    .st_i   (st_q),
    .smp_i  (smp_q),
    .st_o   (st_d),
    .done_o (done_d)
  );

  // Bias state commits only when the sample moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (adv) begin
      res_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q      <= st_d;
      res_done_q <= done_d;
    end
  end

  assign result_o.valid            = res_vld_q;
  assign result_o.accel_bias_x_out = res_q.acc_x;
  assign result_o.accel_bias_y_out = res_q.acc_y;
  assign result_o.accel_bias_z_out = res_q.acc_z;
  assign result_o.gyro_bias_x_out  = res_q.gyr_x;
  assign result_o.gyro_bias_y_out  = res_q.gyr_y;
  assign result_o.gyro_bias_z_out  = res_q.gyr_z;
  assign result_o.done_res         = res_done_q;

endmodule

@@ rtl/imubac_update.sv @@
// Per-sample bias update: next bias state and done flag from one sample.
// Pure combinational; depends on imubac_pkg.
`timescale 1ns / 1ps

module imubac_update (
  input  imubac_pkg::cfg_t    cfg_i,
  input  imubac_pkg::state_t  st_i,
  input  imubac_pkg::sample_t smp_i,
  output imubac_pkg::state_t  st_o,
  output logic                done_o
);
  import imubac_pkg::*;

  logic                    active;
  logic [StepW-1:0]        step;
  logic signed [StepW+1:0] step_pos;
  logic signed [StepW+1:0] step_neg;
  logic signed [StepW+1:0] one_pos;
  logic signed [StepW+1:0] one_neg;
  logic signed [BiasW-1:0] base_x;
  logic signed [BiasW-1:0] base_y;
  logic signed [BiasW-1:0] base_z;
  logic signed [BiasW:0]   acc_z_ext;
  logic signed [BiasW:0]   grav_ext;

  assign active    = st_i.seen < cfg_i.total_samples;
  assign step      = (st_i.seen < cfg_i.switch_count) ? cfg_i.coarse_step : cfg_i.fine_step;
  assign step_pos  = {2'b00, step};
  assign step_neg  = -step_pos;
  assign one_pos   = (StepW+2)'(1);
  assign one_neg   = -one_pos;
  assign acc_z_ext = {smp_i.accel_z[BiasW-1], smp_i.accel_z};
  assign grav_ext  = {2'b00, cfg_i.gravity_target};

  // A run restarts from the configured initial biases on its first sample.
  assign base_x = (st_i.seen == '0) ? cfg_i.init_x : st_i.acc_x;
  assign base_y = (st_i.seen == '0) ? cfg_i.init_y : st_i.acc_y;
  assign base_z = (st_i.seen == '0) ? cfg_i.init_z : st_i.acc_z;

  // Move one axis against the sign of a reading.
  function automatic logic signed [BiasW-1:0] nudge(
    input logic signed [BiasW-1:0] b,
    input logic                    dec,
    input logic                    inc,
    input logic signed [StepW+1:0] dn,
    input logic signed [StepW+1:0] up
  );
    if (dec) begin
      nudge = sat_add(b, dn);
    end else if (inc) begin
      nudge = sat_add(b, up);
    end else begin
      nudge = b;
    end
  endfunction

  always_comb begin
    st_o = st_i;
    if (active) begin
      st_o.acc_x = nudge(base_x, !smp_i.accel_x[BiasW-1] && (smp_i.accel_x != '0),
                         smp_i.accel_x[BiasW-1], step_neg, step_pos);
      st_o.acc_y = nudge(base_y, !smp_i.accel_y[BiasW-1] && (smp_i.accel_y != '0),
                         smp_i.accel_y[BiasW-1], step_neg, step_pos);
      st_o.acc_z = nudge(base_z, acc_z_ext > grav_ext, acc_z_ext < grav_ext,
                         step_neg, step_pos);
      st_o.gyr_x = nudge(st_i.gyr_x, smp_i.gyro_x > 16'sd1, smp_i.gyro_x < -16'sd1,
                         one_neg, one_pos);
      st_o.gyr_y = nudge(st_i.gyr_y, smp_i.gyro_y > 16'sd1, smp_i.gyro_y < -16'sd1,
                         one_neg, one_pos);
      st_o.gyr_z = nudge(st_i.gyr_z, smp_i.gyro_z > 16'sd1, smp_i.gyro_z < -16'sd1,
                         one_neg, one_pos);
      st_o.seen  = st_i.seen + CountW'(1);
    end
  end

  assign done_o = st_o.seen >= cfg_i.total_samples;

endmodule

@@ verif/imubac_tb_pkg.sv @@
// Bias tracker for the IMU bias auto-calibrator testbench: follows the register
// settings and bias state, predicts each returned word. Depends on imubac_pkg.
`timescale 1ns / 1ps

package imubac_tb_pkg;
  import imubac_pkg::*;

  typedef struct packed {
    logic signed [BiasW-1:0] accel_bias_x;
    logic signed [BiasW-1:0] accel_bias_y;
    logic signed [BiasW-1:0] accel_bias_z;
    logic signed [BiasW-1:0] gyro_bias_x;
    logic signed [BiasW-1:0] gyro_bias_y;
    logic signed [BiasW-1:0] gyro_bias_z;
    logic                    done;
  } bias_word_t;

  class bias_tracker;
    cfg_t                    regs;
    logic signed [BiasW-1:0] acc_est[3];
    logic signed [BiasW-1:0] gyr_est[3];
    logic [CountW-1:0]       samples_seen;
    bias_word_t              expected_biases[$];
    int unsigned             mismatches;

    function new();
      regs.init_x         = '0;
      regs.init_y         = '0;
      regs.init_z         = '0;
      regs.coarse_step    = CoarseStepRst;
      regs.fine_step      = FineStepRst;
      regs.switch_count   = SwitchCountRst;
      regs.total_samples  = TotalSamplesRst;
      regs.gravity_target = GravityRst;
      foreach (acc_est[i]) acc_est[i] = '0;
      foreach (gyr_est[i]) gyr_est[i] = '0;
      samples_seen = '0;
      mismatches   = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgInitBiasX:   regs.init_x = data;
        CfgInitBiasY:   regs.init_y = data;
        CfgInitBiasZ:   regs.init_z = data;
        CfgCoarseStep:  regs.coarse_step = data[StepW-1:0];
        CfgFineStep:    regs.fine_step = data[StepW-1:0];
        CfgSwitchCount: regs.switch_count = data[CountW-1:0];
        CfgTotalSmp:    regs.total_samples = data[CountW-1:0];
        CfgGravity:     regs.gravity_target = data[GravW-1:0];
        default: ;
      endcase
    endfunction

    function logic signed [BiasW-1:0] clamp16(int v);
      if (v > 32767) v = 32767;
      else if (v < -32768) v = -32768;
      return v[BiasW-1:0];
    endfunction

    // Move a bias by step against a reading that lies outside target +/- band.
    function logic signed [BiasW-1:0] nudge(logic signed [BiasW-1:0] bias, int reading,
                                            int target, int band, int step);
      if (reading > target + band) return clamp16(int'(bias) - step);
      if (reading < target - band) return clamp16(int'(bias) + step);
      return bias;
    endfunction

    function void note_sample(sample_t s);
      int         step;
      bias_word_t w;
      if (samples_seen < regs.total_samples) begin
        if (samples_seen == 0) begin
          acc_est[0] = regs.init_x;
          acc_est[1] = regs.init_y;
          acc_est[2] = regs.init_z;
        end
        step = (samples_seen < regs.switch_count) ? int'(regs.coarse_step)
                                                  : int'(regs.fine_step);
        acc_est[0] = nudge(acc_est[0], int'(s.accel_x), 0, 0, step);
        acc_est[1] = nudge(acc_est[1], int'(s.accel_y), 0, 0, step);
        acc_est[2] = nudge(acc_est[2], int'(s.accel_z), int'(regs.gravity_target),
                           0, step);
        gyr_est[0] = nudge(gyr_est[0], int'(s.gyro_x), 0, 1, 1);
        gyr_est[1] = nudge(gyr_est[1], int'(s.gyro_y), 0, 1, 1);
        gyr_est[2] = nudge(gyr_est[2], int'(s.gyro_z), 0, 1, 1);
        samples_seen++;
      end
      w.accel_bias_x = acc_est[0];
      w.accel_bias_y = acc_est[1];
      w.accel_bias_z = acc_est[2];
      w.gyro_bias_x  = gyr_est[0];
      w.gyro_bias_y  = gyr_est[1];
      w.gyro_bias_z  = gyr_est[2];
      w.done         = (samples_seen >= regs.total_samples);
      expected_biases.push_back(w);
    endfunction

    function void compare(string field, logic signed [BiasW-1:0] want,
                          logic signed [BiasW-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(bias_word_t got);
      bias_word_t want;
      if (expected_biases.size() == 0) begin
        $error("bias word returned with no sample outstanding");
        mismatches++;
        return;
      end
      want = expected_biases.pop_front();
      compare("accel_bias_x_out", want.accel_bias_x, got.accel_bias_x);
      compare("accel_bias_y_out", want.accel_bias_y, got.accel_bias_y);
      compare("accel_bias_z_out", want.accel_bias_z, got.accel_bias_z);
      compare("gyro_bias_x_out", want.gyro_bias_x, got.gyro_bias_x);
      compare("gyro_bias_y_out", want.gyro_bias_y, got.gyro_bias_y);
      compare("gyro_bias_z_out", want.gyro_bias_z, got.gyro_bias_z);
      compare("done_res", BiasW'(want.done), BiasW'(got.done));
    endfunction

    function int unsigned pending();
      return expected_biases.size();
    endfunction
  endclass

endpackage

@@ verif/testbench.sv @@
// Top of the IMU bias auto-calibrator testbench: clock, reset, sample driver,
// result checker and watchdog. Depends on imubac_pkg, imubac_if, imubac_tb_pkg.
`timescale 1ns / 1ps

module testbench;
  import imubac_pkg::*;
  import imubac_tb_pkg::*;

  // Cycles with no word moving on either channel before the run is abandoned.
  // The longest honest quiet spell is the receiver's long hold plus a gap.
  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned LongHold    = 60;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned RandomItems = 600;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  imubac_sample_if smp();
  imubac_result_if res();

  bias_tracker tracker;
  cfg_t        regs_next;
  bit          burst_mode;
  bit          hold_requested;
  int unsigned quiet_cycles = 0;

  imu_bias_auto_calibrator_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .sample_i    (smp),
    .result_o    (res)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: abandon the run when no word moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (smp.valid && smp.ready) || (res.valid && res.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Idle cycles before the next word on either side; none in a burst stretch.
  function automatic int draw_gap();
    return burst_mode ? 0 : $urandom_range(0, 10);
  endfunction

  // One axis reading: mostly at or near the level the block compares against,
  // so the dead bands and sign decisions get hit, sometimes full scale.
  function automatic logic signed [BiasW-1:0] pick_axis(int center);
    int v;
    case ($urandom_range(0, 3))
      0: begin
        v = center;
      end
      1: begin
        v = center + $urandom_range(0, 4) - 2;
      end
      2: begin
        v = center + $urandom_range(0, 400) - 200;
      end
      default: begin
        v = $urandom;
      end
    endcase
    return v[BiasW-1:0];
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s.accel_x = pick_axis(0);
    s.accel_y = pick_axis(0);
    s.accel_z = pick_axis(int'(regs_next.gravity_target));
    s.gyro_x  = pick_axis(0);
    s.gyro_y  = pick_axis(0);
    s.gyro_z  = pick_axis(0);
    return s;
  endfunction

  function automatic sample_t make_sample(int ax, int ay, int az, int gx, int gy, int gz);
    sample_t s;
    s.accel_x = ax[BiasW-1:0];
    s.accel_y = ay[BiasW-1:0];
    s.accel_z = az[BiasW-1:0];
    s.gyro_x  = gx[BiasW-1:0];
    s.gyro_y  = gy[BiasW-1:0];
    s.gyro_z  = gz[BiasW-1:0];
    return s;
  endfunction

  // Offer one sample word after a random gap; hold it until accepted, then
  // advance the bias prediction. Returns at the falling edge after acceptance.
  task automatic send_sample(sample_t s);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      smp.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    smp.valid   <= 1'b1;
    smp.accel_x <= s.accel_x;
    smp.accel_y <= s.accel_y;
    smp.accel_z <= s.accel_z;
    smp.gyro_x  <= s.gyro_x;
    smp.gyro_y  <= s.gyro_y;
    smp.gyro_z  <= s.gyro_z;
    do @(posedge clk_i); while (!smp.ready);
    tracker.note_sample(s);
    @(negedge clk_i);
  endtask

  // Random samples; every third stretch of 40 runs without idling.
  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) burst_mode = ((i / 40) % 3 == 1);
      send_sample(random_sample());
    end
    burst_mode = 1'b0;
  endtask

  // Drop valid and wait until every word sent has come back.
  task automatic settle();
    smp.valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
  endtask

  // Write one register; the bits above its width carry noise the block must drop.
  task automatic load_reg(cfg_idx_e idx, logic [CfgDataW-1:0] value, int unsigned width);
    logic [CfgDataW-1:0] mask;
    logic [CfgDataW-1:0] data;
    mask = CfgDataW'((32'd1 << width) - 32'd1);
    data = (CfgDataW'($urandom) & ~mask) | (value & mask);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    tracker.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  // Write the whole register set; call only with nothing in flight.
  task automatic program_regs(cfg_t c);
    load_reg(CfgInitBiasX, c.init_x, BiasW);
    load_reg(CfgInitBiasY, c.init_y, BiasW);
    load_reg(CfgInitBiasZ, c.init_z, BiasW);
    load_reg(CfgCoarseStep, CfgDataW'(c.coarse_step), StepW);
    load_reg(CfgFineStep, CfgDataW'(c.fine_step), StepW);
    load_reg(CfgSwitchCount, CfgDataW'(c.switch_count), CountW);
    load_reg(CfgTotalSmp, CfgDataW'(c.total_samples), CountW);
    load_reg(CfgGravity, CfgDataW'(c.gravity_target), GravW);
    cfg_we <= 1'b0;
  endtask

  // Result side: stall at random (or for the long hold when asked), then take
  // one bias word at a rising edge and check it against the oldest prediction.
  initial begin
    int         stall;
    bias_word_t got;
    res.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = draw_gap();
      if (hold_requested) begin
        stall          = LongHold;
        hold_requested = 1'b0;
      end
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res.ready <= 1'b1;
      do @(posedge clk_i); while (!res.valid);
      got.accel_bias_x = res.accel_bias_x_out;
      got.accel_bias_y = res.accel_bias_y_out;
      got.accel_bias_z = res.accel_bias_z_out;
      got.gyro_bias_x  = res.gyro_bias_x_out;
      got.gyro_bias_y  = res.gyro_bias_y_out;
      got.gyro_bias_z  = res.gyro_bias_z_out;
      got.done         = res.done_res;
      tracker.check_result(got);
      @(negedge clk_i);
    end
  end

  // Stimulus. There is one reset, so the sample counter only ever climbs:
  // the phases raise total_samples step by step to keep the run alive, and
  // the last phase takes it to the top of its range.
  initial begin
    sample_t corner_samples[10];

    tracker   = new();
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    smp.valid   = 1'b0;
    smp.accel_x = '0;
    smp.accel_y = '0;
    smp.accel_z = '0;
    smp.gyro_x  = '0;
    smp.gyro_y  = '0;
    smp.gyro_z  = '0;
    burst_mode     = 1'b0;
    hold_requested = 1'b0;

    // Z target at full scale, X and Y start just inside the limits so the
    // coarse step saturates them, fine step of one after six samples.
    corner_samples[0] = make_sample(-32768, 32767, 32767, 2, -2, 0);
    corner_samples[1] = make_sample(-1, 1, -32768, 1, -1, 32767);
    corner_samples[2] = make_sample(0, 0, 0, -32768, 32767, -1);
    corner_samples[3] = make_sample(1, -1, 32766, 0, 0, 2);
    corner_samples[4] = make_sample(32767, -32768, 1, -2, 2, -32768);
    corner_samples[5] = make_sample(-2, 2, 32767, -1, 1, 1);
    corner_samples[6] = make_sample(-32768, 32767, -32768, 3, -3, -2);
    corner_samples[7] = make_sample(0, 1, 32767, 32767, -32768, 0);
    corner_samples[8] = make_sample(-1, 0, -1, 2, -2, 2);
    corner_samples[9] = make_sample(32767, -32768, 0, -2, 2, -2);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Total of zero: the run is over before it starts, every word is ignored.
    regs_next.init_x         = 16'sd32700;
    regs_next.init_y         = -16'sd32700;
    regs_next.init_z         = -16'sd32700;
    regs_next.coarse_step    = 7'd127;
    regs_next.fine_step      = 7'd1;
    regs_next.switch_count   = 8'd6;
    regs_next.total_samples  = 8'd0;
    regs_next.gravity_target = 15'h7fff;
    program_regs(regs_next);
    repeat (5) send_sample(random_sample());
    settle();

    // Corner words. The first accepted one reloads the initial biases written
    // after reset; three trailing words land after the run has ended.
    regs_next.total_samples = 8'd10;
    program_regs(regs_next);
    foreach (corner_samples[i]) send_sample(corner_samples[i]);
    repeat (3) send_sample(random_sample());
    settle();

    // Zero steps and zero switch count: accel biases must hold.
    regs_next.init_x         = BiasW'($urandom);
    regs_next.init_y         = BiasW'($urandom);
    regs_next.init_z         = BiasW'($urandom);
    regs_next.coarse_step    = 7'd0;
    regs_next.fine_step      = 7'd0;
    regs_next.switch_count   = 8'd0;
    regs_next.total_samples  = 8'd30;
    regs_next.gravity_target = 15'd0;
    program_regs(regs_next);
    run_random(25);
    settle();

    // Random steps with the coarse-to-fine switch inside this stretch. The
    // result side holds off for a long spell so the block backs up.
    regs_next.coarse_step    = StepW'($urandom_range(0, 127));
    regs_next.fine_step      = StepW'($urandom_range(0, 127));
    regs_next.switch_count   = CountW'($urandom_range(30, 90));
    regs_next.total_samples  = 8'd90;
    regs_next.gravity_target = GravW'($urandom_range(0, 32767));
    program_regs(regs_next);
    hold_requested = 1'b1;
    run_random(80);
    settle();

    // Nominal gravity, fresh random steps.
    regs_next.coarse_step    = StepW'($urandom_range(0, 127));
    regs_next.fine_step      = StepW'($urandom_range(0, 127));
    regs_next.switch_count   = CountW'($urandom_range(90, 170));
    regs_next.total_samples  = 8'd170;
    regs_next.gravity_target = GravityRst;
    program_regs(regs_next);
    run_random(100);
    settle();

    // Everything at the top: largest steps, switch count never reached, full
    // run length. The remaining words fall after the run and must be ignored.
    regs_next.init_x         = 16'h8000;
    regs_next.init_y         = 16'h7fff;
    regs_next.init_z         = '0;
    regs_next.coarse_step    = 7'd127;
    regs_next.fine_step      = 7'd127;
    regs_next.switch_count   = 8'd255;
    regs_next.total_samples  = 8'd255;
    regs_next.gravity_target = GravW'($urandom_range(0, 32767));
    program_regs(regs_next);
    run_random(RandomItems - 205);
    settle();

    repeat (DrainCycles) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ imu_bias_auto_calibrator_unit.f @@
rtl/imubac_pkg.sv
rtl/imubac_if.sv
rtl/imubac_update.sv
rtl/imu_bias_auto_calibrator_unit.sv
verif/imubac_tb_pkg.sv
verif/testbench.sv
